// File: design/bhmt_pkg.sv
// types and constants shared by the button hold / multi-tap detector
// no dependencies; imported by bhmt_outbuf and button_hold_multitap_detector_core
package bhmt_pkg;

  localparam int CFG_WIDTH   = 16;
  localparam int TAP_WIDTH   = 4;
  localparam int INDEX_WIDTH = 2;

  localparam logic [TAP_WIDTH-1:0] TAP_MAX = 4'd15;

  // configuration register indexes
  localparam logic [INDEX_WIDTH-1:0] REG_HOLD_TICKS  = 2'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_ADV_TIMEOUT = 2'd1;
  localparam logic [INDEX_WIDTH-1:0] REG_TAP_GAP     = 2'd2;
  localparam logic [INDEX_WIDTH-1:0] REG_TAPS_NEEDED = 2'd3;

  // reset values of the registers
  localparam logic [CFG_WIDTH-1:0] HOLD_TICKS_RESET  = 16'd3000;
  localparam logic [CFG_WIDTH-1:0] ADV_TIMEOUT_RESET = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] TAP_GAP_RESET     = 16'd500;
  localparam logic [TAP_WIDTH-1:0] TAPS_NEEDED_RESET = 4'd4;

  typedef struct packed {
    logic button_level;
    logic adv_start;
    logic adv_cancel;
  } in_t;

  typedef struct packed {
    logic                 hold_fired;
    logic                 adv_timeout_fired;
    logic                 diag_fired;
    logic                 counter_active;
    logic [TAP_WIDTH-1:0] tap_run_length;
  } out_t;

endpackage

// File: design/bhmt_outbuf.sv
// two-entry output buffer (result register plus skid register)
// depends on bhmt_pkg for the result struct
module bhmt_outbuf
  import bhmt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  out_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic main_valid;
  logic skid_valid;
  out_t main_data;
  out_t skid_data;

  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || out_ready) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      main_valid <= 1'b0;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held with empty result register");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_ready |=> main_valid && main_data == $past(skid_data))
    else $error("skid entry not moved to result register");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    main_valid && !out_ready |=> main_valid && $stable(main_data))
    else $error("stalled result changed");

endmodule

// File: design/button_hold_multitap_detector_core.sv
// button hold / multi-tap detector with advertising timeout
// channels:
//   in    : one request per millisecond tick (button level, advertising
//           start and cancel strobes), valid/ready
//   out   : one result per tick (alarm pulses, counter state, tap run
//           length), valid/ready
//   cfg   : register writes by index (hold, advertising timeout, tap gap,
//           taps needed); always ready, write only while idle
// result path: the edge that accepts a request writes its result into the
//   output buffer; the state update is a single pass of small counters and
//   compares between the request and the output buffer
// throughput: one request per cycle while in_ready is high; the output buffer holds two results,
//   so a request is taken while a result waits, and in_ready drops only
//   when both entries are full because the receiver stalls
// reset: synchronous, clears all alarm state and the tap run, sets the
//   time since release to saturated and the registers to their defaults
// depends on bhmt_pkg and bhmt_outbuf
module button_hold_multitap_detector_core
  import bhmt_pkg::*;
#(
  parameter int TIME_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data
);

  // compare width covers both elapsed counts and register values
  localparam int CW = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
  localparam logic [TIME_WIDTH-1:0] TIME_ONE = TIME_WIDTH'(1);

  logic [CFG_WIDTH-1:0] hold_ticks;
  logic [CFG_WIDTH-1:0] adv_timeout_ticks;
  logic [CFG_WIDTH-1:0] tap_gap_ticks;
  logic [TAP_WIDTH-1:0] taps_needed;

  logic                  prev_pressed;
  logic                  counter_running;
  logic                  hold_armed;
  logic [TIME_WIDTH-1:0] hold_elapsed;
  logic                  adv_active;
  logic                  adv_armed;
  logic [TIME_WIDTH-1:0] adv_elapsed;
  logic [TIME_WIDTH-1:0] since_release;
  logic [TAP_WIDTH-1:0]  tap_count;

  logic                  counter_running_next;
  logic                  hold_armed_next;
  logic [TIME_WIDTH-1:0] hold_elapsed_next;
  logic                  adv_active_next;
  logic                  adv_armed_next;
  logic [TIME_WIDTH-1:0] adv_elapsed_next;
  logic [TIME_WIDTH-1:0] since_release_next;
  logic [TAP_WIDTH-1:0]  tap_count_next;

  logic hold_hit;
  logic adv_hit;
  logic diag_hit;
  logic accept;
  out_t result;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks        <= HOLD_TICKS_RESET;
      adv_timeout_ticks <= ADV_TIMEOUT_RESET;
      tap_gap_ticks     <= TAP_GAP_RESET;
      taps_needed       <= TAPS_NEEDED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOLD_TICKS:  hold_ticks        <= cfg_data;
        REG_ADV_TIMEOUT: adv_timeout_ticks <= cfg_data;
        REG_TAP_GAP:     tap_gap_ticks     <= cfg_data;
        REG_TAPS_NEEDED: taps_needed       <= cfg_data[TAP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [TIME_WIDTH-1:0] sr_inc;
    logic [TAP_WIDTH-1:0]  tc;

    counter_running_next = counter_running;
    hold_armed_next      = hold_armed;
    hold_elapsed_next    = hold_elapsed;
    adv_active_next      = adv_active;
    adv_armed_next       = adv_armed;
    adv_elapsed_next     = adv_elapsed;
    tap_count_next       = tap_count;
    hold_hit             = 1'b0;
    adv_hit              = 1'b0;
    diag_hit             = 1'b0;
    tc                   = tap_count;

    sr_inc = (since_release == TIME_MAX) ? since_release : since_release + TIME_ONE;
    since_release_next = sr_inc;

    if (in_data.button_level && !prev_pressed) begin
      counter_running_next = 1'b1;
      hold_armed_next      = 1'b1;
      hold_elapsed_next    = '0;
    end else if (!in_data.button_level && prev_pressed) begin
      if (!adv_active) counter_running_next = 1'b0;
      hold_armed_next = 1'b0;
      // tap run continues only when the gap since the last release is short
      if (CW'(sr_inc) < CW'(tap_gap_ticks)) begin
        if (tap_count < TAP_MAX) tc = tap_count + TAP_WIDTH'(1);
      end else begin
        tc = TAP_WIDTH'(1);
      end
      since_release_next = '0;
      if (tc == taps_needed) begin
        diag_hit = 1'b1;
        tc       = '0;
      end
      tap_count_next = tc;
    end

    if (in_data.adv_cancel) begin
      counter_running_next = 1'b0;
      adv_active_next      = 1'b0;
      adv_armed_next       = 1'b0;
    end else if (in_data.adv_start) begin
      counter_running_next = 1'b1;
      adv_active_next      = 1'b1;
      adv_armed_next       = 1'b1;
      adv_elapsed_next     = '0;
    end

    if (counter_running_next) begin
      if (hold_armed_next) begin
        if (hold_elapsed_next != TIME_MAX) hold_elapsed_next = hold_elapsed_next + TIME_ONE;
        if (CW'(hold_elapsed_next) >= CW'(hold_ticks)) begin
          hold_hit        = 1'b1;
          hold_armed_next = 1'b0;
        end
      end
      if (adv_armed_next) begin
        if (adv_elapsed_next != TIME_MAX) adv_elapsed_next = adv_elapsed_next + TIME_ONE;
        if (CW'(adv_elapsed_next) >= CW'(adv_timeout_ticks)) begin
          adv_hit        = 1'b1;
          adv_armed_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pressed    <= 1'b0;
      counter_running <= 1'b0;
      hold_armed      <= 1'b0;
      hold_elapsed    <= '0;
      adv_active      <= 1'b0;
      adv_armed       <= 1'b0;
      adv_elapsed     <= '0;
      since_release   <= TIME_MAX;
      tap_count       <= '0;
    end else if (accept) begin
      prev_pressed    <= in_data.button_level;
      counter_running <= counter_running_next;
      hold_armed      <= hold_armed_next;
      hold_elapsed    <= hold_elapsed_next;
      adv_active      <= adv_active_next;
      adv_armed       <= adv_armed_next;
      adv_elapsed     <= adv_elapsed_next;
      since_release   <= since_release_next;
      tap_count       <= tap_count_next;
    end
  end

  always_comb begin
    result.hold_fired        = hold_hit;
    result.adv_timeout_fired = adv_hit;
    result.diag_fired        = diag_hit;
    result.counter_active    = counter_running_next;
    result.tap_run_length    = tap_count_next;
  end

  bhmt_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_adv_keeps_counter: assert property (@(posedge clk) disable iff (rst)
    adv_active |-> counter_running)
    else $error("advertising active with counter stopped");

  a_cancel_stops: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.adv_cancel |=> !counter_running && !adv_active && !adv_armed)
    else $error("cancel did not stop counter");

  a_hold_once: assert property (@(posedge clk) disable iff (rst)
    accept && hold_hit |=> !hold_armed)
    else $error("hold alarm still armed after firing");

  a_diag_clears_run: assert property (@(posedge clk) disable iff (rst)
    accept && diag_hit |=> tap_count == '0)
    else $error("tap run not cleared after diagnostic pulse");

endmodule

// File: test/button_hold_multitap_detector_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for button_hold_multitap_detector_core: a tick predictor in a
// scoreboard class, valid/ready drivers with random stalls and register phases
// depends on bhmt_pkg and the detector rtl

import bhmt_pkg::*;

class tick_scoreboard;
  // register copies
  bit [CFG_WIDTH-1:0] hold_limit;
  bit [CFG_WIDTH-1:0] adv_limit;
  bit [CFG_WIDTH-1:0] gap_limit;
  bit [TAP_WIDTH-1:0] taps_target;
  // detector state
  bit                 last_level;
  bit                 running;
  bit                 hold_on;
  bit [CFG_WIDTH-1:0] hold_cnt;
  bit                 adv_live;
  bit                 adv_on;
  bit [CFG_WIDTH-1:0] adv_cnt;
  bit [CFG_WIDTH-1:0] since_rel;
  bit [TAP_WIDTH-1:0] taps;

  out_t expected_ticks[$];
  int   errors;
  int   results_seen;

  function new();
    hold_limit   = HOLD_TICKS_RESET;
    adv_limit    = ADV_TIMEOUT_RESET;
    gap_limit    = TAP_GAP_RESET;
    taps_target  = TAPS_NEEDED_RESET;
    last_level   = 1'b0;
    running      = 1'b0;
    hold_on      = 1'b0;
    hold_cnt     = '0;
    adv_live     = 1'b0;
    adv_on       = 1'b0;
    adv_cnt      = '0;
    since_rel    = '1;
    taps         = '0;
    errors       = 0;
    results_seen = 0;
  endfunction

  // time counters stop at all ones
  function bit [CFG_WIDTH-1:0] bump(bit [CFG_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function void write_reg(logic [INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
    case (idx)
      REG_HOLD_TICKS:  hold_limit = val;
      REG_ADV_TIMEOUT: adv_limit = val;
      REG_TAP_GAP:     gap_limit = val;
      REG_TAPS_NEEDED: taps_target = val[TAP_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  function out_t advance_tick(in_t t);
    out_t r;
    r = '0;
    since_rel = bump(since_rel);
    if (t.button_level && !last_level) begin
      running  = 1'b1;
      hold_on  = 1'b1;
      hold_cnt = '0;
    end else if (!t.button_level && last_level) begin
      if (!adv_live) running = 1'b0;
      hold_on = 1'b0;
      if (since_rel < gap_limit) begin
        if (taps != TAP_MAX) taps = taps + 1'b1;
      end else begin
        taps = TAP_WIDTH'(1);
      end
      since_rel = '0;
      if (taps == taps_target) begin
        r.diag_fired = 1'b1;
        taps = '0;
      end
    end
    last_level = t.button_level;
    // cancel wins over start
    if (t.adv_cancel) begin
      running  = 1'b0;
      adv_live = 1'b0;
      adv_on   = 1'b0;
    end else if (t.adv_start) begin
      running  = 1'b1;
      adv_live = 1'b1;
      adv_on   = 1'b1;
      adv_cnt  = '0;
    end
    if (running) begin
      if (hold_on) begin
        hold_cnt = bump(hold_cnt);
        if (hold_cnt >= hold_limit) begin
          r.hold_fired = 1'b1;
          hold_on = 1'b0;
        end
      end
      if (adv_on) begin
        adv_cnt = bump(adv_cnt);
        if (adv_cnt >= adv_limit) begin
          r.adv_timeout_fired = 1'b1;
          adv_on = 1'b0;
        end
      end
    end
    r.counter_active = running;
    r.tap_run_length = taps;
    return r;
  endfunction

  function void note_request(in_t t);
    expected_ticks.push_back(advance_tick(t));
  endfunction

  function void check_result(out_t got);
    out_t exp;
    bit   bad;
    results_seen++;
    if (expected_ticks.size() == 0) begin
      if (errors < 10)
        $display("result %0d arrived with no request outstanding: %p", results_seen, got);
      errors++;
      return;
    end
    exp = expected_ticks.pop_front();
    bad = (got.hold_fired !== exp.hold_fired)
       || (got.adv_timeout_fired !== exp.adv_timeout_fired)
       || (got.diag_fired !== exp.diag_fired)
       || (got.counter_active !== exp.counter_active)
       || (got.tap_run_length !== exp.tap_run_length);
    if (bad) begin
      if (errors < 10) begin
        $display("result %0d mismatch: expected hold=%0b adv=%0b diag=%0b active=%0b taps=%0d",
                 results_seen, exp.hold_fired, exp.adv_timeout_fired, exp.diag_fired,
                 exp.counter_active, exp.tap_run_length);
        $display("                      got hold=%0b adv=%0b diag=%0b active=%0b taps=%0d",
                 got.hold_fired, got.adv_timeout_fired, got.diag_fired,
                 got.counter_active, got.tap_run_length);
      end
      errors++;
    end
  endfunction

  function int pending();
    return expected_ticks.size();
  endfunction
endclass

module button_hold_multitap_detector_core_tb;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0]   cfg_data = '0;

  bit             stall_en = 1'b1;
  int             cycle_count = 0;
  tick_scoreboard sb;

  button_hold_multitap_detector_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** button_hold_multitap_detector_core: FAILED **");
      $finish;
    end
  end

  // result side: check what the edge accepts, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= stall_en ? ($urandom_range(99) >= 24) : 1'b1;
    end
  end

  task automatic send_tick(in_t t);
    while (stall_en && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_request(t);
  endtask

  task automatic drive(bit lvl, bit start, bit cancel);
    in_t t;
    t.button_level = lvl;
    t.adv_start    = start;
    t.adv_cancel   = cancel;
    send_tick(t);
  endtask

  // a stretch of one button level with sparse advertising strobes
  task automatic hold_level(bit lvl, int ticks);
    repeat (ticks) drive(lvl, $urandom_range(99) < 5, $urandom_range(99) < 3);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [CFG_WIDTH-1:0] hold, logic [CFG_WIDTH-1:0] adv,
                           logic [CFG_WIDTH-1:0] gap, logic [TAP_WIDTH-1:0] taps);
    write_reg(REG_HOLD_TICKS, hold);
    write_reg(REG_ADV_TIMEOUT, adv);
    write_reg(REG_TAP_GAP, gap);
    write_reg(REG_TAPS_NEEDED, {{(CFG_WIDTH-TAP_WIDTH){1'b0}}, taps});
    cfg_valid <= 1'b0;
  endtask

  // mostly press/release pairs around the thresholds, some raw noise ticks
  task automatic random_phase(int n_items, int max_press, int max_gap);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(1, max_press);
        hold_level(1'b1, len);
        sent += len;
        len = $urandom_range(1, max_gap);
        hold_level(1'b0, len);
        sent += len;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) drive(1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
        sent += len;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default registers straight out of reset
    drive(1'b1, 1'b0, 1'b0);
    drive(1'b1, 1'b0, 1'b0);
    drive(1'b0, 1'b0, 1'b0);
    drive(1'b0, 1'b0, 1'b0);
    drain();

    configure(16'd3, 16'd4, 16'd6, 4'd2);
    drive(1'b0, 1'b0, 1'b0);
    repeat (3) drive(1'b1, 1'b0, 1'b0);   // hold fires on the third tick
    drive(1'b0, 1'b0, 1'b0);              // first tap
    drive(1'b1, 1'b0, 1'b0);
    drive(1'b0, 1'b0, 1'b0);              // second tap, diagnostic pulse
    drive(1'b0, 1'b1, 1'b1);              // start and cancel, cancel wins
    drive(1'b0, 1'b1, 1'b0);
    repeat (4) drive(1'b0, 1'b0, 1'b0);   // advertising timeout
    drive(1'b1, 1'b0, 1'b0);
    drive(1'b0, 1'b0, 1'b0);              // release keeps counter running
    drive(1'b1, 1'b0, 1'b1);              // press with cancel, hold paused
    drive(1'b1, 1'b0, 1'b0);
    drive(1'b1, 1'b1, 1'b0);              // restart resumes the hold count
    drive(1'b1, 1'b0, 1'b0);
    drive(1'b1, 1'b0, 1'b0);
    drive(1'b0, 1'b0, 1'b1);
    drain();

    // zero thresholds, endless gap, no tap target: run saturates at the top
    configure(16'd0, 16'd0, 16'hFFFF, 4'd0);
    random_phase(200, 6, 6);
    drain();

    // alarms out of reach, no gap, every tap fires
    configure(16'hFFFF, 16'hFFFF, 16'd0, 4'd1);
    random_phase(150, 8, 8);
    drain();

    stall_en <= 1'b0;
    configure(16'd5, 16'd12, 16'd8, 4'd2);
    random_phase(120, 10, 12);
    drain();
    random_phase(130, 10, 12);
    drain();
    stall_en <= 1'b1;

    configure(16'd20, 16'd40, 16'd15, TAP_MAX);
    random_phase(250, 30, 10);
    drain();

    for (int i = 0; i < 4; i++) begin
      configure(CFG_WIDTH'($urandom_range(1, 30)), CFG_WIDTH'($urandom_range(1, 60)),
                CFG_WIDTH'($urandom_range(2, 20)), TAP_WIDTH'($urandom_range(2, 6)));
      random_phase(200, 35, 25);
      drain();
    end

    configure(CFG_WIDTH'($urandom_range(0, 65535)), CFG_WIDTH'($urandom_range(0, 65535)),
              CFG_WIDTH'($urandom_range(0, 65535)), TAP_WIDTH'($urandom_range(0, 15)));
    random_phase(150, 20, 20);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** button_hold_multitap_detector_core: PASSED **");
    end else begin
      $display("** button_hold_multitap_detector_core: FAILED **");
    end
    $finish;
  end
endmodule
